// File: hw/rtl/bldc_pkg.sv
// shared widths, mode and action codes, sine table and commutation helper
package bldc_pkg;

  localparam int MODE_W    = 2;
  localparam int POS_W     = 9;
  localparam int ANGLE_W   = 32;
  localparam int MAG_W     = 10;
  localparam int DRIVE_W   = 11;
  localparam int CMP_W     = 11;
  localparam int QSINE_W   = 15;
  localparam int QIDX_W    = 7;
  localparam int ACT_W     = 3;

  localparam int PWM_PERIOD_DEF = 2000;
  localparam int MIN_COMPARE    = 10;

  localparam logic [MODE_W-1:0] MODE_CLOSED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SECTOR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SINE   = 2'd2;

  // commutation actions, named by the phase pair that carries +p/-p
  localparam logic [ACT_W-1:0] ACT_VP_WN = 3'd0;
  localparam logic [ACT_W-1:0] ACT_VP_UN = 3'd1;
  localparam logic [ACT_W-1:0] ACT_WP_UN = 3'd2;
  localparam logic [ACT_W-1:0] ACT_WP_VN = 3'd3;
  localparam logic [ACT_W-1:0] ACT_UP_VN = 3'd4;
  localparam logic [ACT_W-1:0] ACT_UP_WN = 3'd5;

  typedef logic signed [DRIVE_W-1:0] drive_t;

  typedef struct packed {
    drive_t u;
    drive_t v;
    drive_t w;
  } phase_vals_t;

  // quarter wave sine, 0..90 degrees, q0.15 rounded, top entry saturated
  localparam logic [QSINE_W-1:0] QSINE [0:90] = '{
    15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,  15'd2856,  15'd3425,
    15'd3993,  15'd4560,  15'd5126,  15'd5690,  15'd6252,  15'd6813,  15'd7371,
    15'd7927,  15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668, 15'd11207,
    15'd11743, 15'd12275, 15'd12803, 15'd13328, 15'd13848, 15'd14365, 15'd14876,
    15'd15384, 15'd15886, 15'd16384, 15'd16877, 15'd17364, 15'd17847, 15'd18324,
    15'd18795, 15'd19261, 15'd19720, 15'd20174, 15'd20622, 15'd21063, 15'd21498,
    15'd21926, 15'd22348, 15'd22763, 15'd23170, 15'd23571, 15'd23965, 15'd24351,
    15'd24730, 15'd25102, 15'd25466, 15'd25822, 15'd26170, 15'd26510, 15'd26842,
    15'd27166, 15'd27482, 15'd27789, 15'd28088, 15'd28378, 15'd28660, 15'd28932,
    15'd29197, 15'd29452, 15'd29698, 15'd29935, 15'd30163, 15'd30382, 15'd30592,
    15'd30792, 15'd30983, 15'd31164, 15'd31336, 15'd31499, 15'd31651, 15'd31795,
    15'd31928, 15'd32052, 15'd32166, 15'd32270, 15'd32365, 15'd32449, 15'd32524,
    15'd32588, 15'd32643, 15'd32688, 15'd32723, 15'd32748, 15'd32763, 15'd32767
  };

  function automatic phase_vals_t commute(input logic [ACT_W-1:0] act, input drive_t p);
    phase_vals_t r;
    drive_t      n;
    n = -p;
    r = '0;
    case (act)
      ACT_VP_WN: begin r.v = p; r.w = n; end
      ACT_VP_UN: begin r.u = n; r.v = p; end
      ACT_WP_UN: begin r.u = n; r.w = p; end
      ACT_WP_VN: begin r.v = n; r.w = p; end
      ACT_UP_VN: begin r.u = p; r.v = n; end
      default:   begin r.u = p; r.w = n; end
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/bldc_sine_lane.sv
// one sine lane: quadrant fold, table lookup and q0.15 scale toward zero
module bldc_sine_lane import bldc_pkg::*; (
  input  logic [POS_W-1:0] angle_i,
  input  drive_t           drive_i,
  output drive_t           value_o
);

  logic [POS_W-1:0]      fold;
  logic                  s_neg;
  logic [QSINE_W-1:0]    s_mag;
  logic [DRIVE_W-1:0]    d_abs;
  logic [MAG_W+QSINE_W-1:0] prod;
  logic [DRIVE_W-1:0]    m;

  always_comb begin
    if (angle_i <= POS_W'(90)) begin
      fold  = angle_i;
      s_neg = 1'b0;
    end else if (angle_i <= POS_W'(180)) begin
      fold  = POS_W'(180) - angle_i;
      s_neg = 1'b0;
    end else if (angle_i <= POS_W'(270)) begin
      fold  = angle_i - POS_W'(180);
      s_neg = 1'b1;
    end else begin
      fold  = POS_W'(360) - angle_i;
      s_neg = 1'b1;
    end
  end

  assign s_mag = QSINE[fold[QIDX_W-1:0]];
  assign d_abs = drive_i[DRIVE_W-1] ? DRIVE_W'(-drive_i) : DRIVE_W'(drive_i);
  assign prod  = d_abs[MAG_W-1:0] * s_mag;
  assign m     = {1'b0, prod[MAG_W+QSINE_W-1:QSINE_W]};

  // sign of the product; a zero magnitude gives zero either way
  assign value_o = (drive_i[DRIVE_W-1] != s_neg) ? -$signed(m) : $signed(m);

endmodule

// File: hw/rtl/bldc_cmp_load.sv
// phase enable and compare load with clamp to the pwm window
module bldc_cmp_load import bldc_pkg::*; #(
  parameter int PWM_PERIOD = PWM_PERIOD_DEF
) (
  input  drive_t           value_i,
  input  logic [CMP_W-1:0] cmp_q_i,
  output logic             on_o,
  output logic [CMP_W-1:0] cmp_d_o
);

  localparam int SW = $clog2(PWM_PERIOD + 1024) + 1;
  localparam logic signed [SW-1:0] HALF = SW'(PWM_PERIOD / 2);
  localparam logic signed [SW-1:0] LO   = SW'(MIN_COMPARE);
  localparam logic signed [SW-1:0] HI   = SW'(PWM_PERIOD - MIN_COMPARE);

  logic signed [SW-1:0] c;
  logic signed [SW-1:0] c_clamp;

  assign c = $signed({{(SW-DRIVE_W){value_i[DRIVE_W-1]}}, value_i}) + HALF;

  always_comb begin
    if (c < LO) begin
      c_clamp = LO;
    end else if (c > HI) begin
      c_clamp = HI;
    end else begin
      c_clamp = c;
    end
  end

  assign on_o    = (value_i != '0);
  assign cmp_d_o = on_o ? c_clamp[CMP_W-1:0] : cmp_q_i;

endmodule

// File: hw/rtl/bldc_six_step_commutator.sv
// top level: six-step and sine phase drive with held level and compares
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------
//  in       | sink      | in_valid_i / in_stall_o | mode, position, current/target angle
//  out      | source    | out_valid_o/ out_stall_i| phase on/compare x3, drive_out
//  cfg      | sink      | cfg_valid_i/ cfg_ready_o| drive magnitude
//
// one item per cycle sustained while the result is not stalled; an item is held in the input
// register and leaves through the result register; the path between the two is one table
// lookup, a 10x15 multiply and the clamp
// reset clears the drive level, the compares and the drive magnitude
// a stalled result holds the result register; the input register still takes
// one more item, then in_stall_o rises until the result is taken
module bldc_six_step_commutator import bldc_pkg::*; #(
  parameter int PWM_PERIOD = PWM_PERIOD_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [MAG_W-1:0]          cfg_drive_magnitude_i,
  // input items
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [MODE_W-1:0]         mode_i,
  input  logic [POS_W-1:0]          position_i,
  input  logic signed [ANGLE_W-1:0] current_angle_i,
  input  logic signed [ANGLE_W-1:0] target_angle_i,
  // result items
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      phase_u_on_o,
  output logic [CMP_W-1:0]          phase_u_compare_o,
  output logic                      phase_v_on_o,
  output logic [CMP_W-1:0]          phase_v_compare_o,
  output logic                      phase_w_on_o,
  output logic [CMP_W-1:0]          phase_w_compare_o,
  output logic signed [DRIVE_W-1:0] drive_out_o
);

  // configuration register, always ready
  logic [MAG_W-1:0] drive_mag_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_mag_q <= '0;
    end else if (cfg_valid_i) begin
      drive_mag_q <= cfg_drive_magnitude_i;
    end
  end

  // input register
  logic                      s1_valid_q, s1_valid_d;
  logic [MODE_W-1:0]         s1_mode_q;
  logic [POS_W-1:0]          s1_pos_q;
  logic signed [ANGLE_W-1:0] s1_cur_q;
  logic signed [ANGLE_W-1:0] s1_tgt_q;
  logic                      s1_load;
  logic                      s1_adv;

  logic out_valid_q, out_valid_d;

  // the input register moves on whenever the result register is free or draining
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_mode_q <= mode_i;
      s1_pos_q  <= position_i;
      s1_cur_q  <= current_angle_i;
      s1_tgt_q  <= target_angle_i;
    end
  end

  // held state; the compares and drive level double as result payload since
  // they only change when a new result is loaded
  drive_t           drive_level_q, drive_level_d;
  logic [CMP_W-1:0] cmp_u_q, cmp_u_d;
  logic [CMP_W-1:0] cmp_v_q, cmp_v_d;
  logic [CMP_W-1:0] cmp_w_q, cmp_w_d;

  // hall action = (sector + 2) mod 6 over the full position, by reciprocal
  logic [POS_W:0]       sec2;
  logic [POS_W+8:0]     sec_prod;
  logic [POS_W-2:0]     sec_quot;
  logic [POS_W:0]       sec_rem;
  logic [ACT_W-1:0]     act;

  assign sec2     = {1'b0, s1_pos_q} + (POS_W+1)'(2);
  assign sec_prod = sec2 * 8'd171;
  assign sec_quot = sec_prod[POS_W+8:10];
  assign sec_rem  = sec2 - ({2'b0, sec_quot} * (POS_W+1)'(6));
  assign act      = sec_rem[ACT_W-1:0];

  // sine angles, each brought back into 0..359
  logic [POS_W-1:0] ang_a;
  logic [POS_W:0]   ang_b_raw, ang_c_raw;
  logic [POS_W-1:0] ang_b, ang_c;

  assign ang_a     = (s1_pos_q >= POS_W'(360)) ? s1_pos_q - POS_W'(360) : s1_pos_q;
  assign ang_b_raw = {1'b0, ang_a} + (POS_W+1)'(120);
  assign ang_c_raw = {1'b0, ang_a} + (POS_W+1)'(240);
  assign ang_b     = (ang_b_raw >= (POS_W+1)'(360)) ? POS_W'(ang_b_raw - (POS_W+1)'(360))
                                                   : ang_b_raw[POS_W-1:0];
  assign ang_c     = (ang_c_raw >= (POS_W+1)'(360)) ? POS_W'(ang_c_raw - (POS_W+1)'(360))
                                                   : ang_c_raw[POS_W-1:0];

  drive_t sine_u, sine_v, sine_w;

  bldc_sine_lane u_sine_u (.angle_i(ang_a), .drive_i(drive_level_q), .value_o(sine_u));
  bldc_sine_lane u_sine_v (.angle_i(ang_b), .drive_i(drive_level_q), .value_o(sine_v));
  bldc_sine_lane u_sine_w (.angle_i(ang_c), .drive_i(drive_level_q), .value_o(sine_w));

  // closed loop level: +mag below target, -mag above, zero when equal
  drive_t      mag_pos;
  drive_t      loop_level;
  logic        ang_eq;
  phase_vals_t ph;

  assign mag_pos    = $signed({1'b0, drive_mag_q});
  assign ang_eq     = (s1_cur_q == s1_tgt_q);
  assign loop_level = (s1_cur_q < s1_tgt_q) ? mag_pos : -mag_pos;

  always_comb begin
    drive_level_d = drive_level_q;
    ph            = '0;
    case (s1_mode_q)
      MODE_CLOSED: begin
        if (ang_eq) begin
          drive_level_d = '0;
        end else begin
          drive_level_d = loop_level;
          ph            = commute(act, loop_level);
        end
      end
      MODE_SECTOR: begin
        ph = commute(act, drive_level_q);
      end
      MODE_SINE: begin
        ph.u = sine_u;
        ph.v = sine_v;
        ph.w = sine_w;
      end
      default: begin
        // unused mode: everything off, level held
        ph = '0;
      end
    endcase
  end

  logic on_u, on_v, on_w;

  bldc_cmp_load #(.PWM_PERIOD(PWM_PERIOD)) u_cmp_u (
    .value_i(ph.u), .cmp_q_i(cmp_u_q), .on_o(on_u), .cmp_d_o(cmp_u_d)
  );
  bldc_cmp_load #(.PWM_PERIOD(PWM_PERIOD)) u_cmp_v (
    .value_i(ph.v), .cmp_q_i(cmp_v_q), .on_o(on_v), .cmp_d_o(cmp_v_d)
  );
  bldc_cmp_load #(.PWM_PERIOD(PWM_PERIOD)) u_cmp_w (
    .value_i(ph.w), .cmp_q_i(cmp_w_q), .on_o(on_w), .cmp_d_o(cmp_w_d)
  );

  // result register and state update, both on the advance of the input register
  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      drive_level_q <= '0;
      cmp_u_q       <= '0;
      cmp_v_q       <= '0;
      cmp_w_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        drive_level_q <= drive_level_d;
        cmp_u_q       <= cmp_u_d;
        cmp_v_q       <= cmp_v_d;
        cmp_w_q       <= cmp_w_d;
      end
    end
  end

  logic on_u_q, on_v_q, on_w_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      on_u_q <= on_u;
      on_v_q <= on_v;
      on_w_q <= on_w;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign phase_u_on_o      = on_u_q;
  assign phase_v_on_o      = on_v_q;
  assign phase_w_on_o      = on_w_q;
  assign phase_u_compare_o = cmp_u_q;
  assign phase_v_compare_o = cmp_v_q;
  assign phase_w_compare_o = cmp_w_q;
  assign drive_out_o       = drive_level_q;

endmodule

// File: hw/rtl/bldc_checker.sv
// port level checks for the commutator, bound to the top level
module bldc_checker import bldc_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic                      phase_u_on_o,
  input logic [CMP_W-1:0]          phase_u_compare_o,
  input logic                      phase_v_on_o,
  input logic [CMP_W-1:0]          phase_v_compare_o,
  input logic                      phase_w_on_o,
  input logic [CMP_W-1:0]          phase_w_compare_o,
  input logic signed [DRIVE_W-1:0] drive_out_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // zero drive never enables a phase
  a_zero_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (drive_out_o == '0) |->
      !phase_u_on_o && !phase_v_on_o && !phase_w_on_o)
    else $error("phase enabled at zero drive");

  // a compare only moves with a new result that enables its phase
  a_cmp_u: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(phase_u_compare_o) |-> out_valid_o && phase_u_on_o)
    else $error("phase u compare moved while off");

  a_cmp_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(phase_v_compare_o) |-> out_valid_o && phase_v_on_o)
    else $error("phase v compare moved while off");

  a_cmp_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(phase_w_compare_o) |-> out_valid_o && phase_w_on_o)
    else $error("phase w compare moved while off");

endmodule

bind bldc_six_step_commutator bldc_checker u_bldc_checker (.*);
